FILE: rtl/assert_macros.svh
// assertion helpers for the golay codec checker
// each macro expects a signal named clk in the using scope; all but the last also expect rst
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is high
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("golay checker: implication failed");

// next-cycle implication, off while reset is high
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("golay checker: next-cycle implication failed");

// next-cycle implication that also holds across reset
`define ASSERT_NEXT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("golay checker: reset behavior failed");

`endif

FILE: rtl/golay_pkg.sv
// ----------------------------------------------------------------------------
// golay_pkg
// shared types, constants and syndrome functions of the golay (24,12) codec
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package golay_pkg;

  localparam int BODY_W = 23;
  localparam int DATA_W = 12;
  localparam int SYN_W  = 11;
  localparam int CODE_W = 24;
  localparam int CNT_W  = 4;
  localparam int TRIAL_W = 5;

  localparam logic [BODY_W-1:0] G24_POLY = 23'h000AE3;

  // last trial index: no flip, then a flip of each body bit
  localparam logic [TRIAL_W-1:0] LAST_TRIAL = TRIAL_W'(BODY_W);

  localparam logic [CNT_W-1:0] LIMIT_PLAIN   = 4'd3;
  localparam logic [CNT_W-1:0] LIMIT_FLIPPED = 4'd2;

  localparam logic OP_ENCODE = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  typedef enum logic [0:0] {
    S_IDLE,
    S_RUN
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic store;
  } ctrl_cmd_t;

  typedef struct packed {
    logic finish;
  } dp_stat_t;

  typedef logic [BODY_W-1:0][SYN_W-1:0] col_tbl_t;

  // remainder of each single-bit word, evaluated at elaboration
  function automatic col_tbl_t build_cols();
    col_tbl_t cols;
    logic [BODY_W-1:0] w;
    for (int i = 0; i < BODY_W; i++) begin
      w = BODY_W'(1) << i;
      for (int k = 0; k < DATA_W; k++) begin
        if (w[0]) begin
          w = w ^ G24_POLY;
        end
        w = w >> 1;
      end
      cols[i] = w[SYN_W-1:0];
    end
    return cols;
  endfunction

  localparam col_tbl_t SYN_COLS = build_cols();

  // remainder is linear: xor of the columns of the set bits
  function automatic logic [SYN_W-1:0] syndrome(logic [BODY_W-1:0] w);
    logic [SYN_W-1:0] s;
    s = '0;
    for (int i = 0; i < BODY_W; i++) begin
      if (w[i]) begin
        s = s ^ SYN_COLS[i];
      end
    end
    return s;
  endfunction

  function automatic logic [CNT_W-1:0] ones11(logic [SYN_W-1:0] v);
    logic [CNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < SYN_W; i++) begin
      n = n + CNT_W'(v[i]);
    end
    return n;
  endfunction

  function automatic logic [BODY_W-1:0] rotl23(logic [BODY_W-1:0] w, logic [TRIAL_W-1:0] r);
    logic [BODY_W-1:0] lo;
    logic [BODY_W-1:0] hi;
    lo = w << r;
    hi = w >> (TRIAL_W'(BODY_W) - r);
    return lo | hi;
  endfunction

  function automatic logic [BODY_W-1:0] rotr23(logic [BODY_W-1:0] w, logic [TRIAL_W-1:0] r);
    logic [BODY_W-1:0] lo;
    logic [BODY_W-1:0] hi;
    lo = w >> r;
    hi = w << (TRIAL_W'(BODY_W) - r);
    return lo | hi;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/golay_if.sv
// ----------------------------------------------------------------------------
// golay_if
// valid/ready channels for codec items and results
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface golay_item_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [23:0] word_in;

  modport source (output valid, output operation, output word_in, input ready);
  modport sink (input valid, input operation, input word_in, output ready);
endinterface

interface golay_result_if;
  logic        valid;
  logic        ready;
  logic [23:0] code_out;
  logic [11:0] data_out;
  logic [3:0]  error_count;
  logic        parity_fail;

  modport source (
    output valid, output code_out, output data_out, output error_count,
    output parity_fail, input ready
  );
  modport sink (
    input valid, input code_out, input data_out, input error_count,
    input parity_fail, output ready
  );
endinterface

`default_nettype wire

FILE: rtl/golay_ctrl.sv
// ----------------------------------------------------------------------------
// golay_ctrl
// sequencer: takes an item, steps the trial loop, hands off the result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module golay_ctrl (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire                   out_ready,
  output golay_pkg::ctrl_cmd_t  cmd,
  input  golay_pkg::dp_stat_t   stat
);

  golay_pkg::state_t state;
  golay_pkg::state_t state_next;
  logic              out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= golay_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  assign in_ready = (state == golay_pkg::S_IDLE) && !rst;

  always_comb begin
    state_next     = state;
    cmd            = '0;
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      golay_pkg::S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load   = 1'b1;
          state_next = golay_pkg::S_RUN;
        end
      end
      golay_pkg::S_RUN: begin
        if (!stat.finish) begin
          cmd.step = 1'b1;
        end else if (!out_valid || out_ready) begin
          cmd.store      = 1'b1;
          out_valid_next = 1'b1;
          state_next     = golay_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = golay_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/golay_dp.sv
// ----------------------------------------------------------------------------
// golay_dp
// codec datapath: encoder, one trapping trial per cycle, result registers
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module golay_dp (
  input  wire                   clk,
  input  golay_pkg::ctrl_cmd_t  cmd,
  output golay_pkg::dp_stat_t   stat,
  input  wire                   operation,
  input  wire [23:0]            word_in,
  output logic [23:0]           code_out,
  output logic [11:0]           data_out,
  output logic [3:0]            error_count,
  output logic                  parity_fail
);

  localparam int BW = golay_pkg::BODY_W;
  localparam int SW = golay_pkg::SYN_W;
  localparam int DW = golay_pkg::DATA_W;
  localparam int CW = golay_pkg::CNT_W;
  localparam int TW = golay_pkg::TRIAL_W;

  logic          op;
  logic [BW-1:0] recv;
  logic          pbit;
  logic [TW-1:0] trial;
  logic [CW-1:0] last_wt;

  logic [BW-1:0] cw0;
  logic [CW-1:0] limit;
  logic [SW-1:0] syn [BW];
  logic [CW-1:0] wt [BW];
  logic          hit;
  logic          zero;
  logic [BW-1:0] sel_fix;
  logic [CW-1:0] sel_wt;

  logic [BW-1:0] fixed;
  logic [CW-1:0] cnt;
  logic          pf;
  logic [SW-1:0] enc_syn;
  logic [CW*0+golay_pkg::CODE_W-1:0] enc_code;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op      <= operation;
      recv    <= word_in[BW-1:0];
      pbit    <= word_in[BW];
      trial   <= '0;
      last_wt <= '0;
    end else if (cmd.step) begin
      trial   <= trial + TW'(1);
      last_wt <= wt[BW-1];
    end
  end

  // one trial: all rotations of the current pattern at once
  always_comb begin
    cw0   = recv;
    limit = golay_pkg::LIMIT_PLAIN;
    if (trial != '0) begin
      cw0   = recv ^ (BW'(1) << (trial - TW'(1)));
      limit = golay_pkg::LIMIT_FLIPPED;
    end
    for (int r = 0; r < BW; r++) begin
      syn[r] = golay_pkg::syndrome(golay_pkg::rotl23(cw0, TW'(r)));
      wt[r]  = golay_pkg::ones11(syn[r]);
    end
    zero    = (syn[0] == '0);
    hit     = 1'b0;
    sel_fix = '0;
    sel_wt  = '0;
    for (int r = 0; r < BW; r++) begin
      if (!hit && (wt[r] <= limit)) begin
        hit     = 1'b1;
        sel_fix = golay_pkg::rotr23({syn[r], {DW{1'b0}}}, TW'(r));
        sel_wt  = wt[r];
      end
    end
  end

  always_comb begin
    if (zero) begin
      fixed = cw0;
      cnt   = last_wt;
    end else if (hit) begin
      fixed = cw0 ^ sel_fix;
      cnt   = sel_wt + CW'(trial != '0);
    end else begin
      fixed = recv;
      cnt   = wt[BW-1];
    end
    pf       = ^{pbit, fixed};
    enc_syn  = golay_pkg::syndrome({{(BW-DW){1'b0}}, recv[DW-1:0]});
    enc_code = {^{enc_syn, recv[DW-1:0]}, enc_syn, recv[DW-1:0]};
  end

  assign stat.finish = (op == golay_pkg::OP_ENCODE) || zero || hit ||
                       (trial == golay_pkg::LAST_TRIAL);

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      if (op == golay_pkg::OP_ENCODE) begin
        code_out    <= enc_code;
        data_out    <= '0;
        error_count <= '0;
        parity_fail <= 1'b0;
      end else begin
        code_out    <= '0;
        data_out    <= pf ? '0 : fixed[DW-1:0];
        error_count <= pf ? '0 : cnt;
        parity_fail <= pf;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/golay24_codec.sv
// ----------------------------------------------------------------------------
// golay24_codec
// extended golay (24,12) encoder and error-trapping decoder
// ----------------------------------------------------------------------------
// usage
//   item channel: operation (0 encode, 1 decode) and word_in; encode uses
//   the low 12 bits, decode takes the whole received 24-bit codeword
//   result channel: code_out for encodes, data_out/error_count/parity_fail
//   for decodes; the unused fields read zero
//   one item is in flight at a time; ready drops for the whole item
//   encode: no trials; the result is stored once the output register is free
//   decode: one cycle per trial pattern, up to 24 (no flip, then each of the
//   23 body bits flipped); the trial unit checks all 23 rotations of a
//   pattern at once
//   the next item is taken the cycle after the result is loaded, even while
//   that result still waits in the output register
//   if the receiver stalls, the result holds and a finished item waits in
//   the sequencer until the output register frees up
//   reset clears the sequencer and drops result valid; no other state
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module golay24_codec (
  input  wire              clk,
  input  wire              rst,
  golay_item_if.sink       item,
  golay_result_if.source   result
);

  // command and status between sequencer and datapath
  golay_pkg::ctrl_cmd_t cmd;
  golay_pkg::dp_stat_t  stat;

  // sequencer owns handshakes and result valid
  golay_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // datapath latches the item, runs trials, holds the result fields
  golay_dp u_dp (
    .clk         (clk),
    .cmd         (cmd),
    .stat        (stat),
    .operation   (item.operation),
    .word_in     (item.word_in),
    .code_out    (result.code_out),
    .data_out    (result.data_out),
    .error_count (result.error_count),
    .parity_fail (result.parity_fail)
  );

endmodule

`default_nettype wire

FILE: rtl/golay_chk.sv
// ----------------------------------------------------------------------------
// golay_chk
// port-level checks of the golay codec, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module golay_chk (
  input wire        clk,
  input wire        rst,
  input wire        in_valid,
  input wire        in_ready,
  input wire        out_valid,
  input wire        out_ready,
  input wire [23:0] code_out,
  input wire [11:0] data_out,
  input wire [3:0]  error_count,
  input wire        parity_fail
);

  `ASSERT_NEXT_ALWAYS(a_reset_clears_valid, rst, !out_valid)
  `ASSERT_NEXT(a_one_in_flight, in_valid && in_ready && !rst, !in_ready)
  `ASSERT_IMPL(a_fail_zeroes, out_valid && parity_fail, (data_out == 12'd0) && (error_count == 4'd0))
  `ASSERT_IMPL(a_code_even, out_valid, !(^code_out))
  `ASSERT_NEXT(a_result_holds, out_valid && !out_ready, out_valid && $stable(code_out) && $stable(data_out))

endmodule

bind golay24_codec golay_chk u_chk (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (item.valid),
  .in_ready    (item.ready),
  .out_valid   (result.valid),
  .out_ready   (result.ready),
  .code_out    (result.code_out),
  .data_out    (result.data_out),
  .error_count (result.error_count),
  .parity_fail (result.parity_fail)
);

`default_nettype wire

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the extended golay (24,12) encoder and decoder:
// directed corner items, then random encode items, corrupted codewords with
// 0 to 8 errors and noise words, checked against an internal behavioral predictor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

typedef struct packed {
  logic [23:0] code;
  logic [11:0] data;
  logic [3:0]  count;
  logic        pfail;
} codec_result_t;

// behavioral predictor plus the queue of results still owed by the codec
class codec_ledger;
  codec_result_t owed_results[$];
  int fails;

  function new();
    fails = 0;
  endfunction

  // remainder modulo the generator, placed in bits 12-22
  function logic [22:0] remainder11(logic [22:0] w);
    for (int k = 0; k < 12; k++) begin
      if (w[0]) begin
        w = w ^ golay_pkg::G24_POLY;
      end
      w = w >> 1;
    end
    return w << 12;
  endfunction

  function logic [3:0] weight(logic [22:0] v);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < 23; i++) begin
      n = n + 4'(v[i]);
    end
    return n;
  endfunction

  function logic [23:0] encode_data(logic [11:0] d);
    logic [22:0] body;
    body = remainder11({11'd0, d}) | {11'd0, d};
    return {^body, body};
  endfunction

  // error trapping: plain rotations with limit three, then one forced flip
  // per body bit with limit two
  function logic [22:0] trap_body(logic [22:0] recv, output logic [3:0] count);
    logic [3:0]  cap;
    logic [22:0] cw;
    logic [22:0] s;
    cap = 4'd3;
    cw = recv;
    count = 4'd0;
    for (int flip = -1; flip < 23; flip++) begin
      if (flip >= 0) begin
        cw = recv ^ (23'd1 << flip);
        cap = 4'd2;
      end
      s = remainder11(cw);
      if (s == 23'd0) begin
        return cw;
      end
      for (int r = 0; r < 23; r++) begin
        count = weight(s);
        if (count <= cap) begin
          cw = cw ^ s;
          cw = (cw >> r) | (cw << (23 - r));
          if (flip >= 0) begin
            count = count + 4'd1;
          end
          return cw;
        end
        cw = {cw[21:0], cw[22]};
        s = remainder11(cw);
      end
    end
    return recv;
  endfunction

  function codec_result_t predict_codec(logic op, logic [23:0] word);
    codec_result_t r;
    logic [22:0] fixed;
    logic [3:0]  cnt;
    r = '0;
    if (op == golay_pkg::OP_ENCODE) begin
      r.code = encode_data(word[11:0]);
    end else begin
      fixed = trap_body(word[22:0], cnt);
      if (^{word[23], fixed}) begin
        r.pfail = 1'b1;
      end else begin
        r.data = fixed[11:0];
        r.count = cnt;
      end
    end
    return r;
  endfunction

  function void note_item(logic op, logic [23:0] word);
    owed_results.push_back(predict_codec(op, word));
  endfunction

  function void check_result(logic [23:0] code, logic [11:0] data, logic [3:0] count,
                             logic pfail);
    codec_result_t exp;
    if (owed_results.size() == 0) begin
      $error("result with nothing owed: code_out %h data_out %h", code, data);
      fails++;
      return;
    end
    exp = owed_results.pop_front();
    if (code !== exp.code) begin
      $error("code_out mismatch: expected %h, got %h", exp.code, code);
      fails++;
    end
    if (data !== exp.data) begin
      $error("data_out mismatch: expected %h, got %h", exp.data, data);
      fails++;
    end
    if (count !== exp.count) begin
      $error("error_count mismatch: expected %0d, got %0d", exp.count, count);
      fails++;
    end
    if (pfail !== exp.pfail) begin
      $error("parity_fail mismatch: expected %b, got %b", exp.pfail, pfail);
      fails++;
    end
  endfunction

  function int pending();
    return owed_results.size();
  endfunction
endclass

module testbench;
  logic clk;
  logic rst;

  golay_item_if   item_ch ();
  golay_result_if result_ch ();

  codec_ledger ledger;
  int          sent;

  golay24_codec u_top (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  // 12 ns clock
  initial begin
    clk = 1'b0;
    forever begin
      #6 clk = ~clk;
    end
  end

  // hard stop in case the codec hangs; several times the slowest legal run
  initial begin
    #6_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // idle pattern: 0 never idles, 1 idles uniformly, 2 idles now and then
  function automatic int draw_gap(int mode);
    case (mode)
      0: return 0;
      1: return $urandom_range(12, 0);
      default: return ($urandom_range(3, 0) == 0) ? $urandom_range(12, 1) : 0;
    endcase
  endfunction

  // flip k distinct bits of cw chosen from positions lo..hi
  function automatic logic [23:0] corrupt(logic [23:0] cw, int k, int lo, int hi);
    logic [23:0] mask;
    mask = 24'd0;
    while ($countones(mask) < k) begin
      mask[$urandom_range(hi, lo)] = 1'b1;
    end
    return cw ^ mask;
  endfunction

  // offer one item after a random gap and hold it until the codec takes it;
  // the idle pattern changes every 64 items so bursts with no gap show up too
  int send_mode;

  task automatic send_item(logic op, logic [23:0] word);
    int gap;
    if (sent % 64 == 0) begin
      send_mode = $urandom_range(2, 0);
    end
    gap = draw_gap(send_mode);
    @(negedge clk);
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_ch.valid     <= 1'b1;
    item_ch.operation <= op;
    item_ch.word_in   <= word;
    @(posedge clk);
    while (!item_ch.ready) begin
      @(posedge clk);
    end
    // transaction accepted at this edge
    ledger.note_item(op, word);
    sent++;
  endtask

  task automatic send_decode_of(logic [11:0] d, int k, int lo, int hi);
    send_item(golay_pkg::OP_DECODE, corrupt(ledger.encode_data(d), k, lo, hi));
  endtask

  // result side: random stall before each transaction, one long hold-off
  // partway through so the codec backs up and stalls its input
  initial begin
    int stall;
    int got;
    int recv_mode;
    got = 0;
    recv_mode = 0;
    result_ch.ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      if (got % 50 == 0) begin
        recv_mode = $urandom_range(2, 0);
      end
      stall = (got == 200) ? 300 : draw_gap(recv_mode);
      @(negedge clk);
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      result_ch.ready <= 1'b1;
      @(posedge clk);
      while (!result_ch.valid) begin
        @(posedge clk);
      end
      ledger.check_result(result_ch.code_out, result_ch.data_out, result_ch.error_count,
                          result_ch.parity_fail);
      got++;
    end
  end

  // main sequence
  initial begin
    int pick;
    ledger = new();
    sent = 0;
    send_mode = 0;
    rst = 1'b1;
    item_ch.valid = 1'b0;
    item_ch.operation = golay_pkg::OP_ENCODE;
    item_ch.word_in = 24'd0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: encode extremes, upper bits that encode must ignore
    send_item(golay_pkg::OP_ENCODE, 24'h000000);
    send_item(golay_pkg::OP_ENCODE, 24'h000FFF);
    send_item(golay_pkg::OP_ENCODE, 24'hFFF000);
    send_item(golay_pkg::OP_ENCODE, 24'hFFFFFF);
    send_item(golay_pkg::OP_ENCODE, 24'h000001);
    send_item(golay_pkg::OP_ENCODE, 24'h000800);

    // directed: decode extremes; lone parity bit gives a parity failure
    send_item(golay_pkg::OP_DECODE, 24'h000000);
    send_item(golay_pkg::OP_DECODE, 24'hFFFFFF);
    send_item(golay_pkg::OP_DECODE, 24'h800000);
    // clean codewords: zero syndrome right away
    send_decode_of(12'hFFF, 0, 0, 23);
    send_decode_of(12'(($urandom)), 0, 0, 23);
    // one, two and three body errors
    send_decode_of(12'(($urandom)), 1, 0, 22);
    send_decode_of(12'(($urandom)), 2, 0, 22);
    send_decode_of(12'(($urandom)), 3, 0, 22);
    // three errors in the data bits; these can need the flipped-bit retries
    send_decode_of(12'(($urandom)), 3, 0, 11);
    send_decode_of(12'(($urandom)), 3, 0, 11);
    // parity bit alone, then a body error plus the parity bit
    send_item(golay_pkg::OP_DECODE, ledger.encode_data(12'h5A5) ^ 24'h800000);
    send_item(golay_pkg::OP_DECODE, ledger.encode_data(12'h3C3) ^ 24'h800001);
    // beyond the correction radius: may land on another codeword or
    // exhaust the search
    send_decode_of(12'(($urandom)), 4, 0, 22);
    send_decode_of(12'(($urandom)), 5, 0, 23);
    send_decode_of(12'(($urandom)), 7, 0, 23);
    send_item(golay_pkg::OP_DECODE, 24'($urandom));
    send_item(golay_pkg::OP_DECODE, 24'($urandom));

    // random part: encodes, codewords with few errors, some heavy damage and noise
    for (int i = 0; i < 1500; i++) begin
      pick = $urandom_range(99, 0);
      if (pick < 30) begin
        send_item(golay_pkg::OP_ENCODE, 24'($urandom));
      end else if (pick < 85) begin
        send_decode_of(12'(($urandom)), $urandom_range(3, 0), 0, 23);
      end else if (pick < 95) begin
        send_decode_of(12'(($urandom)), $urandom_range(8, 4), 0, 23);
      end else begin
        send_item(golay_pkg::OP_DECODE, 24'($urandom));
      end
    end

    @(negedge clk);
    item_ch.valid <= 1'b0;

    // drain, then give any stray result time to show up
    while (ledger.pending() != 0) begin
      @(posedge clk);
    end
    repeat (40) @(posedge clk);

    if (ledger.fails == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

FILE: golay24_codec.f
+incdir+rtl
rtl/golay_pkg.sv
rtl/golay_if.sv
rtl/golay_ctrl.sv
rtl/golay_dp.sv
rtl/golay24_codec.sv
rtl/golay_chk.sv
verif/testbench.sv
